// ===== sv/rbs_pkg.sv =====
`timescale 1ns / 1ps

package rbs_pkg;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 1024;

    localparam int PIX_W  = 16;
    localparam int BYTE_W = 8;
    localparam int DIM_W  = 11;
    localparam int RB_W   = 13;
    localparam int DS_W   = 24;
    localparam int POS_W  = 6;
    localparam int PAD_W  = 2;

    localparam logic [DIM_W-1:0] RESET_WIDTH  = 11'd320;
    localparam logic [DIM_W-1:0] RESET_HEIGHT = 11'd240;

    typedef enum logic {
        CFG_WIDTH  = 1'b0,
        CFG_HEIGHT = 1'b1
    } t_cfg_idx;

    localparam logic [BYTE_W-1:0] SIG_B      = 8'h42;
    localparam logic [BYTE_W-1:0] SIG_M      = 8'h4D;
    localparam logic [BYTE_W-1:0] HDR_INFO   = 8'd40;
    localparam logic [BYTE_W-1:0] HDR_PLANES = 8'd1;
    localparam logic [BYTE_W-1:0] HDR_BPP    = 8'd24;

    localparam logic [POS_W-1:0] HDR_LEN    = 6'd54;
    localparam logic [POS_W-1:0] OFS_FSIZE  = 6'd2;
    localparam logic [POS_W-1:0] OFS_DOFF   = 6'd10;
    localparam logic [POS_W-1:0] OFS_HSIZE  = 6'd14;
    localparam logic [POS_W-1:0] OFS_WIDTH  = 6'd18;
    localparam logic [POS_W-1:0] OFS_HEIGHT = 6'd22;
    localparam logic [POS_W-1:0] OFS_PLANES = 6'd26;
    localparam logic [POS_W-1:0] OFS_BPP    = 6'd28;
    localparam logic [POS_W-1:0] OFS_DSIZE  = 6'd34;
    localparam logic [POS_W-1:0] POS_B      = 6'd54;
    localparam logic [POS_W-1:0] POS_G      = 6'd55;
    localparam logic [POS_W-1:0] POS_R      = 6'd56;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             hdr;
        logic [PAD_W-1:0] pad;
        logic             frame_done;
        logic [DIM_W-1:0] w;
        logic [DIM_W-1:0] h;
        logic [RB_W-1:0]  rb;
    } t_cmd;

    typedef logic [BYTE_W-1:0] t_lut5 [32];
    typedef logic [BYTE_W-1:0] t_lut6 [64];

    function automatic t_lut5 f_build_lut5();
        t_lut5 lut;
        for (int i = 0; i < 32; i++) begin
            lut[i] = BYTE_W'((i * 255) / 31);
        end
        return lut;
    endfunction

    function automatic t_lut6 f_build_lut6();
        t_lut6 lut;
        for (int i = 0; i < 64; i++) begin
            lut[i] = BYTE_W'((i * 255) / 63);
        end
        return lut;
    endfunction

    localparam t_lut5 SCALE5 = f_build_lut5();
    localparam t_lut6 SCALE6 = f_build_lut6();

    function automatic logic [BYTE_W-1:0] f_le_byte(input logic [31:0] v,
                                                    input logic [1:0] k);
        logic [BYTE_W-1:0] b;
        case (k)
            2'd0:    b = v[7:0];
            2'd1:    b = v[15:8];
            2'd2:    b = v[23:16];
            default: b = v[31:24];
        endcase
        return b;
    endfunction

endpackage

// ===== sv/rbs_pix_if.sv =====
`timescale 1ns / 1ps

interface rbs_pix_if
    import rbs_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel_rgb565;

    modport source (output valid, output pixel_rgb565, input ready);
    modport sink   (input valid, input pixel_rgb565, output ready);
endinterface

// ===== sv/rbs_byte_if.sv =====
`timescale 1ns / 1ps

interface rbs_byte_if
    import rbs_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
    logic              frame_end;

    modport source (output valid, output out_byte, output run_last, output frame_end,
                    input ready);
    modport sink   (input valid, input out_byte, input run_last, input frame_end,
                    output ready);
endinterface

// ===== sv/rgb565_to_bmp24_stream_top.sv =====
`timescale 1ns / 1ps
// RGB565 pixels in BMP order (bottom row first) enter on i_pix; the 24-bit BMP
// file leaves one byte per request on o_byte. The first pixel of a frame is
// preceded by the 54-byte header; each pixel gives B, G, R; the last pixel of
// a row is followed by 0 to 3 zero pad bytes. run_last marks the final byte
// caused by a pixel, frame_end the final byte of the file.
// Width and height are written through i_cfg_we / i_cfg_idx / i_cfg_data while
// the stream is idle; 0 acts as 1, values above the maximum saturate.
// A pixel's bytes pass through the command queue and the output byte
// register. The output side moves one byte per cycle while the receiver is
// ready and a command is queued. A two-entry command queue lets the pixel
// side keep taking requests while the byte side is busy or stalled; a
// stalled receiver holds o_byte and the queue fills, then i_pix.ready drops.
// Reset restores 320 x 240, empties the queue and starts a new frame with a
// header.

module rgb565_to_bmp24_stream_top
    import rbs_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_idx,
    input  logic [DIM_W-1:0] i_cfg_data,
    rbs_pix_if.sink          i_pix,
    rbs_byte_if.source       o_byte
);

    logic push;
    logic pop;
    logic q_full;
    logic q_valid;
    t_cmd push_cmd;
    t_cmd q_cmd;

    rbs_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_pix      (i_pix),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    rbs_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    rbs_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_cmd   (q_cmd),
        .o_pop     (pop),
        .o_byte    (o_byte)
    );

endmodule

// ===== sv/rbs_cmdq.sv =====
`timescale 1ns / 1ps

module rbs_cmdq
    import rbs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    assign o_full  = r_cnt[1];
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== sv/rbs_front.sv =====
`timescale 1ns / 1ps

module rbs_front
    import rbs_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  t_cfg_idx         i_cfg_idx,
    input  logic [DIM_W-1:0] i_cfg_data,
    rbs_pix_if.sink          i_pix,
    input  logic             i_q_full,
    output logic             o_push,
    output t_cmd             o_cmd
);

    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);

    logic [DIM_W-1:0] r_cfg_w;
    logic [DIM_W-1:0] r_cfg_h;
    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic             r_hdr_sent;

    logic [CW-1:0]    n_col;
    logic [RW-1:0]    n_row;
    logic             n_hdr_sent;

    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [CW-1:0]    col;
    logic [RW-1:0]    row;
    logic             row_end;
    logic             frame_done;
    logic             accept;

    assign i_pix.ready = ~i_q_full;
    assign accept      = i_pix.valid & ~i_q_full;
    assign o_push      = accept;

    always_comb begin
        if (r_cfg_w == '0) begin
            w_eff = DIM_W'(1);
        end else if (32'(r_cfg_w) > MAX_WIDTH) begin
            w_eff = DIM_W'(MAX_WIDTH);
        end else begin
            w_eff = r_cfg_w;
        end
        if (r_cfg_h == '0) begin
            h_eff = DIM_W'(1);
        end else if (32'(r_cfg_h) > MAX_HEIGHT) begin
            h_eff = DIM_W'(MAX_HEIGHT);
        end else begin
            h_eff = r_cfg_h;
        end
    end

    always_comb begin
        col        = r_hdr_sent ? r_col : '0;
        row        = r_hdr_sent ? r_row : '0;
        row_end    = (32'(col) + 32'd1) >= 32'(w_eff);
        frame_done = row_end & ((32'(row) + 32'd1) >= 32'(h_eff));
        n_col      = row_end ? '0 : CW'(32'(col) + 32'd1);
        if (!row_end) begin
            n_row = row;
        end else if (frame_done) begin
            n_row = '0;
        end else begin
            n_row = RW'(32'(row) + 32'd1);
        end
        n_hdr_sent = ~frame_done;
    end

    always_comb begin
        o_cmd.pixel      = i_pix.pixel_rgb565;
        o_cmd.hdr        = ~r_hdr_sent;
        o_cmd.pad        = row_end ? w_eff[1:0] : 2'd0;
        o_cmd.frame_done = frame_done;
        o_cmd.w          = w_eff;
        o_cmd.h          = h_eff;
        o_cmd.rb         = RB_W'({w_eff, 1'b0}) + RB_W'(w_eff) + RB_W'(w_eff[1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= RESET_WIDTH;
            r_cfg_h <= RESET_HEIGHT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIDTH:  r_cfg_w <= i_cfg_data;
                CFG_HEIGHT: r_cfg_h <= i_cfg_data;
                default:    r_cfg_w <= r_cfg_w;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_hdr_sent <= 1'b0;
        end else if (accept) begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_hdr_sent <= n_hdr_sent;
        end
    end

endmodule

// ===== sv/rbs_back.sv =====
`timescale 1ns / 1ps

module rbs_back
    import rbs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_q_valid,
    input  t_cmd i_q_cmd,
    output logic o_pop,
    rbs_byte_if.source o_byte
);

    logic              r_busy;
    logic [POS_W-1:0]  r_pos;
    t_cmd              r_cmd;
    logic [DS_W-1:0]   r_ds;
    logic              r_ov;
    logic [BYTE_W-1:0] r_byte;
    logic              r_run_last;
    logic              r_frame_end;

    logic [BYTE_W-1:0] n_byte;
    logic [31:0]       fsize;
    logic [31:0]       dsize;
    logic              adv;
    logic              emit;
    logic              last;

    assign adv   = ~r_ov | o_byte.ready;
    assign emit  = r_busy & adv;
    assign last  = (r_pos == (POS_R + POS_W'(r_cmd.pad)));
    assign o_pop = i_q_valid & (~r_busy | (emit & last));

    assign dsize = 32'(r_ds);
    assign fsize = 32'(r_ds) + 32'(HDR_LEN);

    always_comb begin
        if (r_pos < OFS_FSIZE) begin
            n_byte = r_pos[0] ? SIG_M : SIG_B;
        end else if (r_pos < OFS_FSIZE + 6'd4) begin
            n_byte = f_le_byte(fsize, 2'(r_pos - OFS_FSIZE));
        end else if (r_pos == OFS_DOFF) begin
            n_byte = BYTE_W'(HDR_LEN);
        end else if (r_pos == OFS_HSIZE) begin
            n_byte = HDR_INFO;
        end else if (r_pos >= OFS_WIDTH && r_pos < OFS_WIDTH + 6'd4) begin
            n_byte = f_le_byte(32'(r_cmd.w), 2'(r_pos - OFS_WIDTH));
        end else if (r_pos >= OFS_HEIGHT && r_pos < OFS_HEIGHT + 6'd4) begin
            n_byte = f_le_byte(32'(r_cmd.h), 2'(r_pos - OFS_HEIGHT));
        end else if (r_pos == OFS_PLANES) begin
            n_byte = HDR_PLANES;
        end else if (r_pos == OFS_BPP) begin
            n_byte = HDR_BPP;
        end else if (r_pos >= OFS_DSIZE && r_pos < OFS_DSIZE + 6'd4) begin
            n_byte = f_le_byte(dsize, 2'(r_pos - OFS_DSIZE));
        end else if (r_pos == POS_B) begin
            n_byte = SCALE5[r_cmd.pixel[4:0]];
        end else if (r_pos == POS_G) begin
            n_byte = SCALE6[r_cmd.pixel[10:5]];
        end else if (r_pos == POS_R) begin
            n_byte = SCALE5[r_cmd.pixel[15:11]];
        end else begin
            n_byte = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd <= i_q_cmd;
            r_ds  <= DS_W'(i_q_cmd.rb) * DS_W'(i_q_cmd.h);
        end
        if (adv) begin
            r_byte      <= n_byte;
            r_run_last  <= last;
            r_frame_end <= last & r_cmd.frame_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_pos  <= '0;
            r_ov   <= 1'b0;
        end else begin
            if (adv) begin
                r_ov <= r_busy;
            end
            if (o_pop) begin
                r_busy <= 1'b1;
                r_pos  <= i_q_cmd.hdr ? '0 : POS_B;
            end else if (emit & last) begin
                r_busy <= 1'b0;
            end else if (emit) begin
                r_pos <= r_pos + POS_W'(1);
            end
        end
    end

    assign o_byte.valid     = r_ov;
    assign o_byte.out_byte  = r_byte;
    assign o_byte.run_last  = r_run_last;
    assign o_byte.frame_end = r_frame_end;

endmodule
